FILE: design/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

   // Default operand width, sign bit included.
   localparam int OPERAND_BITS_DEF = 32;

   // Port field widths, fixed by the stream layout.
   localparam int NUM_W     = 32;
   localparam int DEN_W     = 31;
   localparam int RES_NUM_W = 64;
   localparam int RES_DEN_W = 63;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 136;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_CMP = 2'd3
   } op_type;

   typedef enum logic {
      DIV_NUM = 1'b0,
      DIV_DEN = 1'b1
   } div_sel_type;

   typedef enum logic [1:0] {
      MUL_CROSS_A = 2'd0,
      MUL_CROSS_B = 2'd1,
      MUL_DENS    = 2'd2
   } mul_sel_type;

   // Controller to datapath.
   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sum;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      div_sel_type div_sel;
      logic        capture;
   } ctrl_type;

   // Datapath to controller.
   typedef struct packed {
      logic bad;
      logic is_cmp;
      logic gcd_done;
      logic div_last;
   } stat_type;

endpackage

FILE: design/rational_arith_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat contents (low bit up)
// req_     in   command[1:0] a_num[33:2] a_den[64:34] b_num[96:65] b_den[127:97]
// rsp_     out  res_num[63:0] res_den[126:64] is_less[127] is_equal[128]
//               bad_den[129], zero pad to 136
//
// One request at a time. An arithmetic beat runs the cross multiplies and the
// denominator multiply, a sum, the binary GCD loop (one step per cycle) and
// two restoring divisions of 2*OPERAND_BITS quotient bits each. Compare runs
// only the cross multiplies; a zero denominator skips the multiplies.
// A finished result waits in the output register; the next request is taken
// meanwhile. Reset is synchronous and clears the controller and rsp_tvalid.
module rational_arith_unit #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command, a_num, a_den, b_num, b_den
   input  logic [rau_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // res_num, res_den, is_less, is_equal, bad_den, zero pad
   output logic [rau_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   rau_pkg::ctrl_type ctrl;
   rau_pkg::stat_type stat;

   logic [rau_pkg::RES_NUM_W-1:0] res_num;
   logic [rau_pkg::RES_DEN_W-1:0] res_den;
   logic                          is_less, is_equal, bad_den;

   // Sequence the multiply, reduce and divide steps.
   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   // Hold operands, products, GCD and divider registers, and the result beat.
   rau_dpath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .in_command (req_tdata[1:0]),
      .in_a_num   (req_tdata[33:2]),
      .in_a_den   (req_tdata[64:34]),
      .in_b_num   (req_tdata[96:65]),
      .in_b_den   (req_tdata[127:97]),
      .res_num    (res_num),
      .res_den    (res_den),
      .is_less    (is_less),
      .is_equal   (is_equal),
      .bad_den    (bad_den)
   );

   assign rsp_tdata = {6'd0, bad_den, is_equal, is_less, res_den, res_num};

endmodule

FILE: design/rau_ctrl.sv
`timescale 1ns / 1ps

module rau_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rau_pkg::stat_type  stat,
   output rau_pkg::ctrl_type  ctrl
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_MUL_A    = 10'b00_0000_0010,
      ST_MUL_B    = 10'b00_0000_0100,
      ST_MUL_D    = 10'b00_0000_1000,
      ST_SUM      = 10'b00_0001_0000,
      ST_GCD      = 10'b00_0010_0000,
      ST_DIV_N    = 10'b00_0100_0000,
      ST_DEN_INIT = 10'b00_1000_0000,
      ST_DIV_D    = 10'b01_0000_0000,
      ST_FINISH   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (stat.bad) begin
               state_in = ST_FINISH;
            end else begin
               ctrl.mul_en  = 1'b1;
               ctrl.mul_sel = rau_pkg::MUL_CROSS_A;
               state_in     = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = rau_pkg::MUL_CROSS_B;
            state_in     = stat.is_cmp ? ST_FINISH : ST_MUL_D;
         end
         ST_MUL_D: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = rau_pkg::MUL_DENS;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            ctrl.sum = 1'b1;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            if (stat.gcd_done) begin
               ctrl.div_init = 1'b1;
               ctrl.div_sel  = rau_pkg::DIV_NUM;
               state_in      = ST_DIV_N;
            end else begin
               ctrl.gcd_step = 1'b1;
            end
         end
         ST_DIV_N: begin
            ctrl.div_step = 1'b1;
            ctrl.div_sel  = rau_pkg::DIV_NUM;
            if (stat.div_last) state_in = ST_DEN_INIT;
         end
         ST_DEN_INIT: begin
            ctrl.div_init = 1'b1;
            ctrl.div_sel  = rau_pkg::DIV_DEN;
            state_in      = ST_DIV_D;
         end
         ST_DIV_D: begin
            ctrl.div_step = 1'b1;
            ctrl.div_sel  = rau_pkg::DIV_DEN;
            if (stat.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.capture = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: design/rau_dpath.sv
`timescale 1ns / 1ps

module rau_dpath #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rau_pkg::ctrl_type               ctrl,
   output rau_pkg::stat_type               stat,
   input  logic [1:0]                      in_command,
   input  logic [rau_pkg::NUM_W-1:0]       in_a_num,
   input  logic [rau_pkg::DEN_W-1:0]       in_a_den,
   input  logic [rau_pkg::NUM_W-1:0]       in_b_num,
   input  logic [rau_pkg::DEN_W-1:0]       in_b_den,
   output logic [rau_pkg::RES_NUM_W-1:0]   res_num,
   output logic [rau_pkg::RES_DEN_W-1:0]   res_den,
   output logic                            is_less,
   output logic                            is_equal,
   output logic                            bad_den
);

   localparam int W  = OPERAND_BITS;
   localparam int PW = 2 * W;
   localparam int KW = $clog2(PW) + 1;
   localparam int CW = $clog2(PW);
   localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);
   localparam int RW_NUM = rau_pkg::RES_NUM_W;

   rau_pkg::op_type     op_ff;
   logic signed [W-1:0] an_ff, bn_ff, ad_ff, bd_ff;
   logic                bad_ff;
   logic signed [W-1:0] mx, my;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic [PW-1:0]       d_ff;
   logic signed [PW-1:0] n_sum;
   logic [PW-1:0]       mag_ff, u_ff, v_ff, g_ff;
   logic                neg_ff, common_ff;
   logic [KW-1:0]       k_ff;
   logic [PW-1:0]       q_ff, r_ff, q_in, r_in, r_try;
   logic [CW-1:0]       cnt_ff;
   logic [PW-1:0]       qn_ff, qd_ff;
   logic [rau_pkg::RES_NUM_W-1:0] num_ext;
   logic [rau_pkg::RES_NUM_W-1:0] den_ext;
   logic [rau_pkg::RES_NUM_W-1:0] res_num_ff;
   logic [rau_pkg::RES_DEN_W-1:0] res_den_ff;
   logic                lt_ff, eq_ff, bad_out_ff;

   assign stat.bad      = bad_ff;
   assign stat.is_cmp   = (op_ff == rau_pkg::OP_CMP);
   assign stat.gcd_done = (u_ff == '0);
   assign stat.div_last = (cnt_ff == DIV_LAST);

   // Shared signed multiplier, one product per cycle.
   always_comb begin
      unique case (ctrl.mul_sel)
         rau_pkg::MUL_CROSS_A: begin
            mx = an_ff;
            my = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::MUL_CROSS_B: begin
            mx = bn_ff;
            my = ad_ff;
         end
         default: begin
            mx = ad_ff;
            my = bd_ff;
         end
      endcase
   end
   assign prod = mx * my;

   always_comb begin
      case (op_ff)
         rau_pkg::OP_ADD: n_sum = p1_ff + p2_ff;
         rau_pkg::OP_SUB: n_sum = p1_ff - p2_ff;
         default:         n_sum = p1_ff;
      endcase
   end

   // Restoring divider step.
   assign r_try = {r_ff[PW-2:0], q_ff[PW-1]};
   always_comb begin
      if (r_try >= g_ff) begin
         r_in = r_try - g_ff;
         q_in = {q_ff[PW-2:0], 1'b1};
      end else begin
         r_in = r_try;
         q_in = {q_ff[PW-2:0], 1'b0};
      end
   end

   assign num_ext = RW_NUM'(signed'(neg_ff ? (PW'(0) - qn_ff) : qn_ff));
   assign den_ext = rau_pkg::RES_NUM_W'(qd_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff  <= rau_pkg::op_type'(in_command);
         an_ff  <= in_a_num[W-1:0];
         bn_ff  <= in_b_num[W-1:0];
         ad_ff  <= {1'b0, in_a_den[W-2:0]};
         bd_ff  <= {1'b0, in_b_den[W-2:0]};
         bad_ff <= (in_a_den[W-2:0] == '0) || (in_b_den[W-2:0] == '0);
      end
      if (ctrl.mul_en) begin
         unique case (ctrl.mul_sel)
            rau_pkg::MUL_CROSS_A: p1_ff <= prod;
            rau_pkg::MUL_CROSS_B: p2_ff <= prod;
            default:              d_ff  <= prod;
         endcase
      end
      if (ctrl.sum) begin
         neg_ff    <= n_sum[PW-1];
         mag_ff    <= n_sum[PW-1] ? (PW'(0) - n_sum) : n_sum;
         u_ff      <= n_sum[PW-1] ? (PW'(0) - n_sum) : n_sum;
         v_ff      <= d_ff;
         k_ff      <= '0;
         common_ff <= 1'b1;
      end else if (ctrl.gcd_step) begin
         if (common_ff) begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + KW'(1);
            end else begin
               common_ff <= 1'b0;
            end
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end
      if (ctrl.div_init) begin
         if (ctrl.div_sel == rau_pkg::DIV_NUM) begin
            g_ff <= v_ff << k_ff;
            q_ff <= mag_ff;
         end else begin
            q_ff <= d_ff;
         end
         r_ff   <= '0;
         cnt_ff <= '0;
      end else if (ctrl.div_step) begin
         q_ff   <= q_in;
         r_ff   <= r_in;
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == DIV_LAST) begin
            if (ctrl.div_sel == rau_pkg::DIV_NUM) qn_ff <= q_in;
            else                                  qd_ff <= q_in;
         end
      end
      if (ctrl.capture) begin
         bad_out_ff <= bad_ff;
         if (bad_ff || op_ff == rau_pkg::OP_CMP) begin
            res_num_ff <= '0;
            res_den_ff <= '0;
         end else begin
            res_num_ff <= num_ext;
            res_den_ff <= den_ext[rau_pkg::RES_DEN_W-1:0];
         end
         lt_ff <= !bad_ff && (op_ff == rau_pkg::OP_CMP) && (p1_ff < p2_ff);
         eq_ff <= !bad_ff && (op_ff == rau_pkg::OP_CMP) && (p1_ff == p2_ff);
      end
      if (reset) begin
         bad_out_ff <= 1'b0;
      end
   end

   assign res_num  = res_num_ff;
   assign res_den  = res_den_ff;
   assign is_less  = lt_ff;
   assign is_equal = eq_ff;
   assign bad_den  = bad_out_ff;

endmodule
